>>> hdl/tsb_pkg.sv
// ---------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the texture sampler
// Field layout of the stream beats, register indexes, shared multiply-add
// operation type and fixed-point constants.
// ---------------------------------------------------------------------------
package tsb_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_TEXELS = 4096;

  // Fixed-point and channel formats
  localparam int CHANNEL_BITS    = 8;
  localparam int TEXEL_W         = 4 * CHANNEL_BITS;
  localparam int COORD_W         = 24;
  localparam int COORD_FRAC_BITS = 16;
  localparam int WRAP_W          = COORD_FRAC_BITS + 1;   // wrapped coordinate, 0..1 inclusive
  localparam int SIZE_W          = 7;                     // texture width / height
  localparam int POS_W           = COORD_FRAC_BITS + SIZE_W; // scaled texel position
  localparam int INDEX_W         = 12;

  localparam logic [WRAP_W-1:0] ONE_FX = WRAP_W'(1) << COORD_FRAC_BITS;

  // Slave-side tdata layout, lowest bit first
  localparam int IDX_LSB   = 0;
  localparam int RED_LSB   = IDX_LSB + INDEX_W;
  localparam int GREEN_LSB = RED_LSB + CHANNEL_BITS;
  localparam int BLUE_LSB  = GREEN_LSB + CHANNEL_BITS;
  localparam int ALPHA_LSB = BLUE_LSB + CHANNEL_BITS;
  localparam int U_LSB     = ALPHA_LSB + CHANNEL_BITS;
  localparam int V_LSB     = U_LSB + COORD_W;
  localparam int S_TDATA_W = ((V_LSB + COORD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = TEXEL_W;

  // Request kinds carried in tuser
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SIZE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH   = 3'd0,
    REG_TEX_HEIGHT  = 3'd1,
    REG_WRAP_U_MODE = 3'd2,
    REG_WRAP_V_MODE = 3'd3,
    REG_FILTER_SEL  = 3'd4
  } cfg_reg_t;

  // Mode codes
  localparam logic WRAP_CLAMP      = 1'b0;
  localparam logic WRAP_REPEAT     = 1'b1;
  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  // Shared multiply-add unit: res = (a * b) [>>> frac] + add
  localparam int MUL_A_W = WRAP_W + 1;
  localparam int MUL_B_W = WRAP_W;
  localparam int MAC_W   = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
    logic signed [MUL_A_W-1:0] add;
    logic                      frac_shift;
  } mac_op_t;

endpackage

>>> hdl/tsb_mac.sv
// ---------------------------------------------------------------------------
// tsb_mac: shared multiply-add unit
// One signed multiplier with an optional floor shift by the coordinate
// fraction and an adder; serves coordinate scaling, addressing and blending.
// ---------------------------------------------------------------------------
module tsb_mac (
  input  tsb_pkg::mac_op_t                 op,
  output logic signed [tsb_pkg::MAC_W-1:0] res
);
  import tsb_pkg::*;

  logic signed [MAC_W-1:0] prod;
  logic signed [MAC_W-1:0] scaled;

  // Multiply, then floor the product when blending
  assign prod   = op.a * op.b;
  assign scaled = op.frac_shift ? (prod >>> COORD_FRAC_BITS) : prod;
  assign res    = scaled + MAC_W'(op.add);

endmodule

>>> hdl/tsb_texmem.sv
// ---------------------------------------------------------------------------
// tsb_texmem: texel store
// Single-port RGBA texel memory with a registered read.
// ---------------------------------------------------------------------------
module tsb_texmem #(
  parameter int MAX_TEXELS = tsb_pkg::DEF_MAX_TEXELS,
  parameter int ADDR_W     = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [tsb_pkg::TEXEL_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [tsb_pkg::TEXEL_W-1:0]  rd_data
);
  import tsb_pkg::*;

  logic [TEXEL_W-1:0] mem [MAX_TEXELS];

  // Write a loaded texel, or read one for the sampler
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end else if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/texture_sampler_bilinear.sv
// Beats are taken only in idle; a load beat writes its texel as the beat is accepted.
// Nearest sample: scale u, scale v, address and capture, then the output step.
// Bilinear sample: scale u and v, address and capture per corner, then a top-row, bottom-row
// and between-row blend per channel, then output. The output step waits out back-pressure.
// rst (synchronous) clears the sequencer, output valid and registers to 64, 64, clamp,
// clamp, nearest; the texel store is not cleared and reads as undefined until loaded.
// ---------------------------------------------------------------------------
// texture_sampler_bilinear: texture sampler, nearest or bilinear filtering
// Loads RGBA texels into a store and samples it with repeat or clamp
// wrapping, using a small sequencer around one shared multiply-add unit.
// ---------------------------------------------------------------------------
module texture_sampler_bilinear #(
  parameter int MAX_TEXELS = tsb_pkg::DEF_MAX_TEXELS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata: texel_index[11:0], in_red[19:12], in_green[27:20], in_blue[35:28],
  //        in_alpha[43:36], coord_u[67:44], coord_v[91:68], zero pad[95:92]
  input  logic [tsb_pkg::S_TDATA_W-1:0]   s_tdata,
  // tuser: req_type[0]
  input  logic [0:0]                      s_tuser,
  // Master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [tsb_pkg::M_TDATA_W-1:0]   m_tdata,
  // Configuration write port
  input  logic                            cfg_wr_en,
  input  logic [tsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tsb_pkg::*;

  localparam int ADDR_W = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCALE_U = 7'b0000010,
    S_SCALE_V = 7'b0000100,
    S_ADDR    = 7'b0001000,
    S_CAPT    = 7'b0010000,
    S_LERP    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  localparam logic [1:0] CORNER_00 = 2'd0;
  localparam logic [1:0] CORNER_10 = 2'd1;
  localparam logic [1:0] CORNER_01 = 2'd2;
  localparam logic [1:0] CORNER_11 = 2'd3;
  localparam logic [1:0] LERP_TOP  = 2'd0;
  localparam logic [1:0] LERP_BOT  = 2'd1;
  localparam logic [1:0] LERP_MIX  = 2'd2;
  localparam logic [1:0] LAST_CHAN = 2'd3;

  function automatic logic [WRAP_W-1:0] wrap_coord(input logic signed [COORD_W-1:0] c,
                                                   input logic rep);
    logic [WRAP_W-1:0] r;
    if (rep == WRAP_REPEAT) begin
      r = {1'b0, c[COORD_FRAC_BITS-1:0]};
    end else if (c < 0) begin
      r = '0;
    end else if (c > $signed(COORD_W'(ONE_FX))) begin
      r = ONE_FX;
    end else begin
      r = c[WRAP_W-1:0];
    end
    return r;
  endfunction

  state_t state;

  // Configuration registers
  logic [SIZE_W-1:0] tex_width;
  logic [SIZE_W-1:0] tex_height;
  logic              wrap_u_mode;
  logic              wrap_v_mode;
  logic              filter_sel;

  // Working registers
  logic [WRAP_W-1:0]  wu;
  logic [WRAP_W-1:0]  wv;
  logic [POS_W-1:0]   fx;
  logic [POS_W-1:0]   fy;
  logic [1:0]         corner;
  logic [1:0]         chan;
  logic [1:0]         step;
  logic               rd_ok;
  logic [TEXEL_W-1:0] c00;
  logic [TEXEL_W-1:0] c10;
  logic [TEXEL_W-1:0] c01;
  logic [TEXEL_W-1:0] c11;
  logic [CHANNEL_BITS-1:0] top;
  logic [CHANNEL_BITS-1:0] bot;
  logic [TEXEL_W-1:0] acc;

  // Derived geometry
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] w_m1;
  logic [SIZE_W-1:0] h_m1;
  logic [POS_W-1:0]  fx_rnd;
  logic [POS_W-1:0]  fy_rnd;
  logic [SIZE_W-1:0] x0;
  logic [SIZE_W-1:0] y0;
  logic [SIZE_W-1:0] x1;
  logic [SIZE_W-1:0] y1;
  logic [SIZE_W-1:0] x_sel;
  logic [SIZE_W-1:0] y_sel;

  // Input beat fields
  logic                      s_accept;
  logic [INDEX_W-1:0]        ld_index;
  logic signed [COORD_W-1:0] in_u;
  logic signed [COORD_W-1:0] in_v;
  logic                      ld_ok;

  // Blend operands
  logic [CHANNEL_BITS-1:0]    lerp_a;
  logic [CHANNEL_BITS-1:0]    lerp_b;
  logic [COORD_FRAC_BITS-1:0] lerp_t;
  logic signed [CHANNEL_BITS:0] lerp_diff;

  mac_op_t                 mac_op;
  logic signed [MAC_W-1:0] mac_res;
  logic                    mem_rd_en;
  logic [TEXEL_W-1:0]      mem_rd_data;
  logic [TEXEL_W-1:0]      px_word;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign ld_index = s_tdata[IDX_LSB +: INDEX_W];
  assign in_u     = s_tdata[U_LSB +: COORD_W];
  assign in_v     = s_tdata[V_LSB +: COORD_W];
  assign ld_ok    = (32'(ld_index) < 32'(MAX_TEXELS));

  // Sizes of zero act as one
  assign w_eff  = (tex_width  == '0) ? SIZE_W'(1) : tex_width;
  assign h_eff  = (tex_height == '0) ? SIZE_W'(1) : tex_height;
  assign w_m1   = w_eff - SIZE_W'(1);
  assign h_m1   = h_eff - SIZE_W'(1);
  assign fx_rnd = fx + POS_W'(ONE_FX >> 1);
  assign fy_rnd = fy + POS_W'(ONE_FX >> 1);
  assign x0     = fx[POS_W-1 -: SIZE_W];
  assign y0     = fy[POS_W-1 -: SIZE_W];
  assign x1     = x0 + SIZE_W'(x0 < w_m1);
  assign y1     = y0 + SIZE_W'(y0 < h_m1);

  // Pick the texel coordinates of the current fetch
  always_comb begin
    if (filter_sel == FILTER_NEAREST) begin
      x_sel = fx_rnd[POS_W-1 -: SIZE_W];
      y_sel = fy_rnd[POS_W-1 -: SIZE_W];
    end else begin
      case (corner)
        CORNER_00: begin x_sel = x0; y_sel = y0; end
        CORNER_10: begin x_sel = x1; y_sel = y0; end
        CORNER_01: begin x_sel = x0; y_sel = y1; end
        default:   begin x_sel = x1; y_sel = y1; end
      endcase
    end
  end

  // Pick the blend operands: top row, bottom row, then between rows
  always_comb begin
    case (step)
      LERP_TOP: begin
        lerp_a = c00[CHANNEL_BITS-1:0];
        lerp_b = c10[CHANNEL_BITS-1:0];
        lerp_t = fx[COORD_FRAC_BITS-1:0];
      end
      LERP_BOT: begin
        lerp_a = c01[CHANNEL_BITS-1:0];
        lerp_b = c11[CHANNEL_BITS-1:0];
        lerp_t = fx[COORD_FRAC_BITS-1:0];
      end
      default: begin
        lerp_a = top;
        lerp_b = bot;
        lerp_t = fy[COORD_FRAC_BITS-1:0];
      end
    endcase
  end

  assign lerp_diff = $signed({1'b0, lerp_b}) - $signed({1'b0, lerp_a});

  // Drive the shared unit for the current step
  always_comb begin
    mac_op = '0;
    unique case (state)
      S_SCALE_U: begin
        mac_op.a = MUL_A_W'(wu);
        mac_op.b = MUL_B_W'(w_m1);
      end
      S_SCALE_V: begin
        mac_op.a = MUL_A_W'(wv);
        mac_op.b = MUL_B_W'(h_m1);
      end
      S_ADDR: begin
        mac_op.a   = MUL_A_W'(y_sel);
        mac_op.b   = MUL_B_W'(w_eff);
        mac_op.add = MUL_A_W'(x_sel);
      end
      S_LERP: begin
        mac_op.a          = MUL_A_W'(lerp_diff);
        mac_op.b          = MUL_B_W'(lerp_t);
        mac_op.add        = MUL_A_W'(lerp_a);
        mac_op.frac_shift = 1'b1;
      end
      default: mac_op = '0;
    endcase
  end

  tsb_mac u_mac (
    .op  (mac_op),
    .res (mac_res)
  );

  assign mem_rd_en = (state == S_ADDR);

  tsb_texmem #(
    .MAX_TEXELS (MAX_TEXELS),
    .ADDR_W     (ADDR_W)
  ) u_texmem (
    .clk     (clk),
    .wr_en   (s_accept && (s_tuser[0] == REQ_LOAD) && ld_ok),
    .wr_addr (ADDR_W'(ld_index)),
    .wr_data (s_tdata[RED_LSB +: TEXEL_W]),
    .rd_en   (mem_rd_en),
    .rd_addr (mac_res[ADDR_W-1:0]),
    .rd_data (mem_rd_data)
  );

  // Addresses beyond the store read as zero
  assign px_word = rd_ok ? mem_rd_data : '0;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= SIZE_W'(64);
      tex_height  <= SIZE_W'(64);
      wrap_u_mode <= WRAP_CLAMP;
      wrap_v_mode <= WRAP_CLAMP;
      filter_sel  <= FILTER_NEAREST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:   tex_width   <= cfg_wdata;
        REG_TEX_HEIGHT:  tex_height  <= cfg_wdata;
        REG_WRAP_U_MODE: wrap_u_mode <= cfg_wdata[0];
        REG_WRAP_V_MODE: wrap_v_mode <= cfg_wdata[0];
        REG_FILTER_SEL:  filter_sel  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Raise the result beat from the output step; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      corner   <= CORNER_00;
      chan     <= '0;
      step     <= LERP_TOP;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_accept && (s_tuser[0] == REQ_SAMPLE)) begin
            state <= S_SCALE_U;
          end
        end
        S_SCALE_U: state <= S_SCALE_V;
        S_SCALE_V: begin
          corner <= CORNER_00;
          state  <= S_ADDR;
        end
        S_ADDR: state <= S_CAPT;
        S_CAPT: begin
          if (filter_sel == FILTER_NEAREST) begin
            state <= S_DONE;
          end else if (corner == CORNER_11) begin
            chan  <= '0;
            step  <= LERP_TOP;
            state <= S_LERP;
          end else begin
            corner <= corner + 2'd1;
            state  <= S_ADDR;
          end
        end
        S_LERP: begin
          if (step == LERP_MIX) begin
            step <= LERP_TOP;
            chan <= chan + 2'd1;
            if (chan == LAST_CHAN) begin
              state <= S_DONE;
            end
          end else begin
            step <= step + 2'd1;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        wu <= wrap_coord(in_u, wrap_u_mode);
        wv <= wrap_coord(in_v, wrap_v_mode);
      end
      S_SCALE_U: fx <= mac_res[POS_W-1:0];
      S_SCALE_V: fy <= mac_res[POS_W-1:0];
      S_ADDR:    rd_ok <= ($unsigned(mac_res) < MAC_W'(MAX_TEXELS));
      S_CAPT: begin
        case (corner)
          CORNER_00: c00 <= px_word;
          CORNER_10: c10 <= px_word;
          CORNER_01: c01 <= px_word;
          default:   c11 <= px_word;
        endcase
      end
      S_LERP: begin
        case (step)
          LERP_TOP: top <= mac_res[CHANNEL_BITS-1:0];
          LERP_BOT: bot <= mac_res[CHANNEL_BITS-1:0];
          default: begin
            // Shift the blended channel in and advance every corner by one channel
            acc <= {mac_res[CHANNEL_BITS-1:0], acc[TEXEL_W-1:CHANNEL_BITS]};
            c00 <= c00 >> CHANNEL_BITS;
            c10 <= c10 >> CHANNEL_BITS;
            c01 <= c01 >> CHANNEL_BITS;
            c11 <= c11 >> CHANNEL_BITS;
          end
        endcase
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= (filter_sel == FILTER_NEAREST) ? c00 : acc;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser[0] == REQ_SAMPLE)) |=> (state == S_SCALE_U))
    else $error("sample beat did not start the scale step");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result beat raised outside the output step");

  a_nearest_one_fetch: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CAPT) && (filter_sel == FILTER_NEAREST)) |-> (corner == CORNER_00))
    else $error("nearest sample fetched more than one texel");

  a_lerp_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LERP) |-> (step != 2'd3))
    else $error("blend step out of range");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the bilinear texture sampler
// Streams texel loads and sample requests into the sampler and compares every
// returned colour with a behavioural copy of the store and the filter.
// Directed cases cover the coordinate and size corners. Random phases then
// rewrite the configuration and mix loads with samples under random gaps and
// back-pressure. Before a sample is sent, every texel it reads from the store is loaded.
// ---------------------------------------------------------------------------
module tb_top;
  import tsb_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int MAX_TEXELS    = DEF_MAX_TEXELS;
  localparam int SETTLE_CYCLES = 32;    // above the longest sample latency
  localparam int QUIET_LIMIT   = 1000;  // cycles without any beat before giving up
  localparam int RANDOM_BEATS  = 1450;

  localparam longint FX_ONE  = longint'(1) << COORD_FRAC_BITS;
  localparam longint FX_HALF = FX_ONE >> 1;
  localparam longint FX_MASK = FX_ONE - 1;

  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(FX_ONE);
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic [0:0]             s_tuser   = REQ_LOAD;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_TEX_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Shadow configuration and texel store
  logic [SIZE_W-1:0]      tex_w     = 7'd64;
  logic [SIZE_W-1:0]      tex_h     = 7'd64;
  logic                   rep_u     = WRAP_CLAMP;
  logic                   rep_v     = WRAP_CLAMP;
  logic                   filt_mode = FILTER_NEAREST;
  logic [TEXEL_W-1:0]     texel_mem    [MAX_TEXELS];
  bit                     texel_loaded [MAX_TEXELS];

  // Addresses and weights of the texels behind the current sample
  int                     tap_addr [4];
  longint                 tap_tx;
  longint                 tap_ty;

  logic [TEXEL_W-1:0]     colour_q [$];
  string                  chan_name [4] = '{"out_red", "out_green", "out_blue", "out_alpha"};
  int                     fail_count = 0;
  int                     beats_sent = 0;
  int                     stall_left = 0;
  bit                     tx_gaps    = 1'b1;
  bit                     rx_stalls  = 1'b1;
  bit                     tx_active  = 1'b0;  // s_tvalid has been driven high

  texture_sampler_bilinear #(
    .MAX_TEXELS(MAX_TEXELS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Fold one coordinate into 0..1 as Q.16
  function automatic longint wrap_axis(logic signed [COORD_W-1:0] c, logic mode);
    longint s;
    s = longint'(c);
    if (mode == WRAP_REPEAT) return s & FX_MASK;
    if (s < 0) return 0;
    if (s > FX_ONE) return FX_ONE;
    return s;
  endfunction

  // Work out the four texel addresses and the blend weights of one sample;
  // nearest uses one address four times with zero weights
  function automatic void locate_taps(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    longint w, h, fx, fy, x0, y0, x1, y1;
    w  = (tex_w == 0) ? 1 : longint'(tex_w);
    h  = (tex_h == 0) ? 1 : longint'(tex_h);
    fx = wrap_axis(u, rep_u) * (w - 1);
    fy = wrap_axis(v, rep_v) * (h - 1);
    if (filt_mode == FILTER_NEAREST) begin
      x0 = (fx + FX_HALF) >>> COORD_FRAC_BITS;
      y0 = (fy + FX_HALF) >>> COORD_FRAC_BITS;
      x1 = x0;
      y1 = y0;
      tap_tx = 0;
      tap_ty = 0;
    end else begin
      x0 = fx >>> COORD_FRAC_BITS;
      y0 = fy >>> COORD_FRAC_BITS;
      x1 = (x0 < w - 1) ? x0 + 1 : x0;
      y1 = (y0 < h - 1) ? y0 + 1 : y0;
      tap_tx = fx & FX_MASK;
      tap_ty = fy & FX_MASK;
    end
    tap_addr[0] = int'(y0 * w + x0);
    tap_addr[1] = int'(y0 * w + x1);
    tap_addr[2] = int'(y1 * w + x0);
    tap_addr[3] = int'(y1 * w + x1);
  endfunction

  // a + floor((b - a) * t / 2^16)
  function automatic longint lerp_ch(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> COORD_FRAC_BITS);
  endfunction

  // Blend the located texels; addresses past the store read as zero
  function automatic logic [TEXEL_W-1:0] blend_taps();
    logic [TEXEL_W-1:0] c [4];
    logic [TEXEL_W-1:0] res;
    longint top, bot;
    for (int k = 0; k < 4; k++)
      c[k] = (tap_addr[k] < MAX_TEXELS) ? texel_mem[tap_addr[k]] : '0;
    for (int ch = 0; ch < 4; ch++) begin
      top = lerp_ch(c[0][ch*CHANNEL_BITS +: CHANNEL_BITS], c[1][ch*CHANNEL_BITS +: CHANNEL_BITS],
                    tap_tx);
      bot = lerp_ch(c[2][ch*CHANNEL_BITS +: CHANNEL_BITS], c[3][ch*CHANNEL_BITS +: CHANNEL_BITS],
                    tap_tx);
      res[ch*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(lerp_ch(top, bot, tap_ty));
    end
    return res;
  endfunction

  // Texel channels sit back to back from red up, so the whole texel drops in at RED_LSB
  function automatic logic [S_TDATA_W-1:0] pack_item(logic [INDEX_W-1:0] idx,
                                                     logic [TEXEL_W-1:0] texel,
                                                     logic [COORD_W-1:0] u,
                                                     logic [COORD_W-1:0] v);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[IDX_LSB +: INDEX_W] = idx;
    d[RED_LSB +: TEXEL_W] = texel;
    d[U_LSB   +: COORD_W] = u;
    d[V_LSB   +: COORD_W] = v;
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return COORD_W'(longint'($urandom_range(0, 4 * FX_ONE)) - 2 * FX_ONE);
      6: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return COORD_ONE;
          2: return COORD_ONE - COORD_W'(1);
          3: return '1;
          default: return COORD_W'(FX_HALF);
        endcase
      end
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return SIZE_W'($urandom_range(65, 127));
      default: return SIZE_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Offer one beat after a random gap and hold it until taken
  task automatic send_beat(logic kind, logic [S_TDATA_W-1:0] data);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      if (tx_active) s_tvalid <= 1'b0;
      tx_active = 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    tx_active = 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_load(logic [INDEX_W-1:0] idx, logic [TEXEL_W-1:0] texel);
    texel_mem[idx]    = texel;
    texel_loaded[idx] = 1'b1;
    send_beat(REQ_LOAD, pack_item(idx, texel, COORD_W'($urandom()), COORD_W'($urandom())));
  endtask

  // Load any texel the sample will read that holds nothing yet, then send it
  task automatic send_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    locate_taps(u, v);
    for (int k = 0; k < 4; k++)
      if (tap_addr[k] < MAX_TEXELS && !texel_loaded[tap_addr[k]])
        send_load(INDEX_W'(tap_addr[k]), TEXEL_W'($urandom()));
    colour_q.push_back(blend_taps());
    send_beat(REQ_SAMPLE, pack_item(INDEX_W'($urandom()), TEXEL_W'($urandom()), u, v));
  endtask

  // Hold the sender off until every result is back
  task automatic drain_results();
    if (tx_active) begin
      s_tvalid <= 1'b0;
      tx_active = 1'b0;
      @(posedge clk);
    end
    while (colour_q.size() != 0) @(posedge clk);
  endtask

  // Rewrite all five registers once the sampler has gone quiet
  task automatic apply_config(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                              logic ru, logic rv, logic flt);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TEX_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_TEX_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= REG_WRAP_U_MODE;
    cfg_wdata <= CFG_DATA_W'(ru);
    @(posedge clk);
    cfg_index <= REG_WRAP_V_MODE;
    cfg_wdata <= CFG_DATA_W'(rv);
    @(posedge clk);
    cfg_index <= REG_FILTER_SEL;
    cfg_wdata <= CFG_DATA_W'(flt);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tex_w     = w;
    tex_h     = h;
    rep_u     = ru;
    rep_v     = rv;
    filt_mode = flt;
  endtask

  // Registers untouched since reset: 64 x 64, clamp, nearest
  task automatic test_reset_defaults();
    send_load('0, '1);
    send_load(INDEX_W'(MAX_TEXELS - 1), '0);
    send_sample('0, '0);
    send_sample(COORD_ONE, COORD_ONE);
    send_sample(COORD_MIN, COORD_MAX);
  endtask

  // Repeat against clamp on each axis, half-way rounding, negative coordinates
  task automatic test_wrap_modes();
    apply_config(7'd3, 7'd5, WRAP_REPEAT, WRAP_CLAMP, FILTER_NEAREST);
    send_sample(24'h004000, 24'h008000);
    send_sample(24'hFFC000, 24'hFFFFFF);
    send_sample(COORD_MAX, COORD_ONE);
    apply_config(7'd3, 7'd5, WRAP_CLAMP, WRAP_REPEAT, FILTER_NEAREST);
    send_sample(24'h010001, 24'h018000);
    send_sample(COORD_MIN, 24'hFF0000);
  endtask

  // Falling blend between full and empty texels, last column and row, repeat
  task automatic test_bilinear_edges();
    apply_config(7'd4, 7'd4, WRAP_CLAMP, WRAP_CLAMP, FILTER_BILINEAR);
    send_load(12'd1, '0);
    send_sample(24'h005555, '0);
    send_sample(COORD_ONE, COORD_ONE);
    send_sample(24'h008000, 24'h00C000);
    drain_results();
    apply_config(7'd4, 7'd4, WRAP_REPEAT, WRAP_REPEAT, FILTER_BILINEAR);
    send_sample(24'hFFFFFF, 24'hFF8001);
    send_sample(24'h00FFFF, COORD_MAX);
  endtask

  // Zero sizes act as one; oversized textures read zero past the store
  task automatic test_size_extremes();
    apply_config(7'd0, 7'd0, WRAP_CLAMP, WRAP_CLAMP, FILTER_NEAREST);
    send_sample(COORD_ONE, 24'h012345);
    apply_config(7'd0, 7'd1, WRAP_REPEAT, WRAP_REPEAT, FILTER_BILINEAR);
    send_sample(24'h00ABCD, 24'h001234);
    apply_config(7'd127, 7'd127, WRAP_CLAMP, WRAP_CLAMP, FILTER_BILINEAR);
    send_sample(COORD_ONE, COORD_ONE);
    send_sample(24'h008000, 24'h008000);
    send_sample(24'h001000, 24'h004000);
    apply_config(7'd65, 7'd1, WRAP_CLAMP, WRAP_CLAMP, FILTER_NEAREST);
    send_sample(24'h00C000, '0);
    apply_config(7'd1, 7'd64, WRAP_REPEAT, WRAP_CLAMP, FILTER_BILINEAR);
    send_sample(24'h00C000, 24'h00FF00);
  endtask

  // Random phases: fresh configuration, then loads and samples mixed
  task automatic test_random_traffic();
    int target, left, area;
    logic [SIZE_W-1:0] w, h;
    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      w = pick_size();
      h = pick_size();
      apply_config(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls <= ($urandom_range(0, 3) != 0);
      area = ((w == 0) ? 1 : int'(w)) * ((h == 0) ? 1 : int'(h));
      if (area > MAX_TEXELS) area = MAX_TEXELS;
      left = $urandom_range(60, 140);
      while (left > 0 && beats_sent < target) begin
        if ($urandom_range(0, 3) == 0)
          send_load(($urandom_range(0, 9) < 8) ? INDEX_W'($urandom_range(0, area - 1))
                                                : INDEX_W'($urandom_range(0, MAX_TEXELS - 1)),
                    TEXEL_W'($urandom()));
        else
          send_sample(rand_coord(), rand_coord());
        if ($urandom_range(0, 49) == 0) drain_results();
        left--;
      end
    end
  endtask

  // Check each result beat against the oldest predicted colour; draw the next stall
  always @(posedge clk) begin : result_check
    logic [TEXEL_W-1:0] want;
    int nxt;
    if (rst) begin
      stall_left <= 0;
      m_tready   <= 1'b0;
    end else begin
      nxt = (stall_left > 0) ? stall_left - 1 : 0;
      if (m_tvalid && m_tready) begin
        if (colour_q.size() == 0) begin
          $error("result beat %h with no sample outstanding", m_tdata);
          fail_count++;
        end else begin
          want = colour_q.pop_front();
          for (int ch = 0; ch < 4; ch++)
            if (m_tdata[ch*CHANNEL_BITS +: CHANNEL_BITS] != want[ch*CHANNEL_BITS +: CHANNEL_BITS])
            begin
              $error("%s: expected %0d, actual %0d", chan_name[ch],
                     want[ch*CHANNEL_BITS +: CHANNEL_BITS],
                     m_tdata[ch*CHANNEL_BITS +: CHANNEL_BITS]);
              fail_count++;
            end
        end
        nxt = rx_stalls ? $urandom_range(0, 7) : 0;
      end
      stall_left <= nxt;
      m_tready   <= (nxt == 0);
    end
  end

  // Abort when no beat moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_wrap_modes();
    test_bilinear_edges();
    test_size_extremes();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && colour_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
